>>> rtl/vrgr_pkg.sv
// Shared constants, types and helpers for the vertical RGBA gradient row block.
package vrgr_pkg;

    localparam int NCH           = 4;   // r, g, b, a lanes
    localparam int CH_W          = 8;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_W      = 13;
    localparam int COLOR_W       = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int BITS_PER_STEP = 2;   // quotient bits resolved per divider stage
    localparam int NSTEP         = CH_W / BITS_PER_STEP;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PANEL_HEIGHT = 2'd0,
        CFG_TOP_COLOR    = 2'd1,
        CFG_BOTTOM_COLOR = 2'd2
    } t_cfg_idx;

    typedef logic [CH_W-1:0] t_chan;

    // Lane k of a packed colour, lane 0 being red in the top byte.
    function automatic t_chan chan_of(input logic [COLOR_W-1:0] color, input int k);
        return color[COLOR_W-1-CH_W*k -: CH_W];
    endfunction

endpackage

>>> rtl/vrgr_prep.sv
// First pipeline stage: row clamp and per-lane magnitude and sign of the colour step.
module vrgr_prep #(
    parameter int DW = 12
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic [vrgr_pkg::ROW_W-1:0]                   i_row,
    input  logic [DW-1:0]                                i_div,
    input  logic [vrgr_pkg::COLOR_W-1:0]                 i_top,
    input  logic [vrgr_pkg::COLOR_W-1:0]                 i_bot,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic [DW-1:0]                                o_row,
    output logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] o_mag,
    output logic [vrgr_pkg::NCH-1:0]                     o_neg,
    output logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] o_base
);
    import vrgr_pkg::*;

    localparam int CMP_W = (DW > ROW_W) ? DW : ROW_W;

    logic                            r_valid;
    logic [DW-1:0]                   r_row,  n_row;
    logic [NCH-1:0][CH_W-1:0]        r_mag,  n_mag;
    logic [NCH-1:0]                  r_neg,  n_neg;
    logic [NCH-1:0][CH_W-1:0]        r_base, n_base;

    assign o_ready = ~r_valid | i_ready;

    always_comb begin
        t_chan a;
        t_chan b;
        if (CMP_W'(i_row) > CMP_W'(i_div)) begin
            n_row = i_div;
        end else begin
            n_row = DW'(CMP_W'(i_row));
        end
        for (int k = 0; k < NCH; k++) begin
            a = chan_of(i_top, k);
            b = chan_of(i_bot, k);
            n_base[k] = a;
            n_neg[k]  = (b < a);
            n_mag[k]  = (b < a) ? (a - b) : (b - a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_row  <= n_row;
            r_mag  <= n_mag;
            r_neg  <= n_neg;
            r_base <= n_base;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
    assign o_base  = r_base;

endmodule

>>> rtl/vrgr_mul.sv
// Second pipeline stage: magnitude times clamped row, one multiplier per lane.
module vrgr_mul #(
    parameter int DW = 12,
    parameter int NW = 20
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic [DW-1:0]                                i_row,
    input  logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] i_mag,
    input  logic [vrgr_pkg::NCH-1:0]                     i_neg,
    input  logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] i_base,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic [vrgr_pkg::NCH-1:0][NW-1:0]             o_num,
    output logic [vrgr_pkg::NCH-1:0]                     o_neg,
    output logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] o_base
);
    import vrgr_pkg::*;

    logic                     r_valid;
    logic [NCH-1:0][NW-1:0]   r_num, n_num;
    logic [NCH-1:0]           r_neg;
    logic [NCH-1:0][CH_W-1:0] r_base;

    assign o_ready = ~r_valid | i_ready;

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            n_num[k] = NW'(i_mag[k]) * NW'(i_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_num  <= n_num;
            r_neg  <= i_neg;
            r_base <= i_base;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_neg   = r_neg;
    assign o_base  = r_base;

endmodule

>>> rtl/vrgr_div_step.sv
// One restoring-divider stage: resolves BITS_PER_STEP quotient bits on every lane.
module vrgr_div_step #(
    parameter int DW   = 12,
    parameter int NW   = 20,
    parameter int STEP = 0
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic [DW-1:0]                                i_div,
    input  logic [vrgr_pkg::NCH-1:0][NW-1:0]             i_rem,
    input  logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] i_quo,
    input  logic [vrgr_pkg::NCH-1:0]                     i_neg,
    input  logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] i_base,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic [vrgr_pkg::NCH-1:0][NW-1:0]             o_rem,
    output logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] o_quo,
    output logic [vrgr_pkg::NCH-1:0]                     o_neg,
    output logic [vrgr_pkg::NCH-1:0][vrgr_pkg::CH_W-1:0] o_base
);
    import vrgr_pkg::*;

    localparam int HI = CH_W - 1 - BITS_PER_STEP * STEP;

    logic                     r_valid;
    logic [NCH-1:0][NW-1:0]   r_rem, n_rem;
    logic [NCH-1:0][CH_W-1:0] r_quo, n_quo;
    logic [NCH-1:0]           r_neg;
    logic [NCH-1:0][CH_W-1:0] r_base;

    assign o_ready = ~r_valid | i_ready;

    // Quotient never exceeds 255, so the remainder is always below div << 8.
    always_comb begin
        logic [NW-1:0] trial;
        n_rem = i_rem;
        n_quo = i_quo;
        for (int k = 0; k < NCH; k++) begin
            for (int b = 0; b < BITS_PER_STEP; b++) begin
                trial = NW'(i_div) << (HI - b);
                if (n_rem[k] >= trial) begin
                    n_rem[k]        = n_rem[k] - trial;
                    n_quo[k][HI-b]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_neg  <= i_neg;
            r_base <= i_base;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_neg   = r_neg;
    assign o_base  = r_base;

endmodule

>>> rtl/vertical_rgba_gradient_row.sv
// Top level of the vertical RGBA gradient row generator: config, pipeline, output register.
//
//  channel  direction  handshake                   payload
//  row      in         i_row_valid / o_row_ready   i_row_index
//  pix      out        o_pix_valid / i_pix_ready   o_red, o_green, o_blue, o_alpha
//  cfg      in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Seven register stages: clamp, multiply, four divider stages (two quotient bits
// each), sign fix-up into the output register. One item per cycle unless stalled.
// Each stage has its own valid bit and takes a new item when empty or when its
// successor takes; a stalled output holds while bubbles further up still fill.
// Synchronous active-low reset clears the valid bits and the config registers.
module vertical_rgba_gradient_row #(
    parameter int MAX_ROWS = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_row_valid,
    output logic                               o_row_ready,
    input  logic [vrgr_pkg::ROW_W-1:0]         i_row_index,
    output logic                               o_pix_valid,
    input  logic                               i_pix_ready,
    output logic [vrgr_pkg::CH_W-1:0]          o_red,
    output logic [vrgr_pkg::CH_W-1:0]          o_green,
    output logic [vrgr_pkg::CH_W-1:0]          o_blue,
    output logic [vrgr_pkg::CH_W-1:0]          o_alpha,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vrgr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vrgr_pkg::COLOR_W-1:0]       i_cfg_data
);
    import vrgr_pkg::*;

    // Divisor width: the divisor is at most MAX_ROWS - 1.
    localparam int DW  = $clog2(MAX_ROWS);
    localparam int NW  = DW + CH_W;
    localparam int HW0 = DW + 1;
    localparam int HW  = (HW0 > HEIGHT_W) ? HW0 : HEIGHT_W;

    // ---- configuration registers ----
    logic [HEIGHT_W-1:0] r_panel_height;
    logic [COLOR_W-1:0]  r_top_color;
    logic [COLOR_W-1:0]  r_bottom_color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_height <= '0;
            r_top_color    <= '0;
            r_bottom_color <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PANEL_HEIGHT: r_panel_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_TOP_COLOR:    r_top_color    <= i_cfg_data;
                CFG_BOTTOM_COLOR: r_bottom_color <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---- divisor: saturate height to MAX_ROWS, then height - 1, never below 1 ----
    // The user must change config only while the pipeline is empty (the block does
    // not enforce it); only then does this stay steady for every item in flight.
    logic [HW-1:0] w_hsat;
    logic [HW-1:0] w_div_full;
    logic [DW-1:0] w_div;

    always_comb begin
        if (HW'(r_panel_height) > HW'(MAX_ROWS)) begin
            w_hsat = HW'(MAX_ROWS);
        end else begin
            w_hsat = HW'(r_panel_height);
        end
        if (w_hsat > HW'(1)) begin
            w_div_full = w_hsat - HW'(1);
        end else begin
            w_div_full = HW'(1);
        end
    end

    assign w_div = w_div_full[DW-1:0];

    // ---- stage 1: clamp and colour step ----
    logic                     w_p_valid, w_p_ready;
    logic [DW-1:0]            w_p_row;
    logic [NCH-1:0][CH_W-1:0] w_p_mag;
    logic [NCH-1:0]           w_p_neg;
    logic [NCH-1:0][CH_W-1:0] w_p_base;

    vrgr_prep #(.DW(DW)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_row_valid),
        .o_ready (o_row_ready),
        .i_row   (i_row_index),
        .i_div   (w_div),
        .i_top   (r_top_color),
        .i_bot   (r_bottom_color),
        .o_valid (w_p_valid),
        .i_ready (w_p_ready),
        .o_row   (w_p_row),
        .o_mag   (w_p_mag),
        .o_neg   (w_p_neg),
        .o_base  (w_p_base)
    );

    // ---- stage 2: product |step| * row, the dividend ----
    // Slot 0 of the chain arrays is the multiplier output; slot s+1 the output
    // of divider stage s.
    logic [NSTEP:0]                     w_valid;
    logic [NSTEP:0]                     w_ready;
    logic [NSTEP:0][NCH-1:0][NW-1:0]    w_rem;
    logic [NSTEP:0][NCH-1:0][CH_W-1:0]  w_quo;
    logic [NSTEP:0][NCH-1:0]            w_neg;
    logic [NSTEP:0][NCH-1:0][CH_W-1:0]  w_base;

    vrgr_mul #(.DW(DW), .NW(NW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p_valid),
        .o_ready (w_p_ready),
        .i_row   (w_p_row),
        .i_mag   (w_p_mag),
        .i_neg   (w_p_neg),
        .i_base  (w_p_base),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_num   (w_rem[0]),
        .o_neg   (w_neg[0]),
        .o_base  (w_base[0])
    );

    assign w_quo[0] = '0;

    // ---- stages 3..6: unsigned divide by the divisor, MSB first ----
    for (genvar s = 0; s < NSTEP; s++) begin : g_div
        vrgr_div_step #(.DW(DW), .NW(NW), .STEP(s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_div   (w_div),
            .i_rem   (w_rem[s]),
            .i_quo   (w_quo[s]),
            .i_neg   (w_neg[s]),
            .i_base  (w_base[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_quo   (w_quo[s+1]),
            .o_neg   (w_neg[s+1]),
            .o_base  (w_base[s+1])
        );
    end

    // ---- stage 7: top +/- quotient into the output register ----
    // Truncating division of a signed step equals the sign applied to the
    // unsigned quotient of its magnitude; the sum always stays in 0..255.
    logic                     r_out_valid;
    logic [NCH-1:0][CH_W-1:0] r_chan, n_chan;
    logic                     w_out_take;

    assign w_ready[NSTEP] = ~r_out_valid | i_pix_ready;
    assign w_out_take     = w_ready[NSTEP] & w_valid[NSTEP];

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            if (w_neg[NSTEP][k]) begin
                n_chan[k] = w_base[NSTEP][k] - w_quo[NSTEP][k];
            end else begin
                n_chan[k] = w_base[NSTEP][k] + w_quo[NSTEP][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[NSTEP]) begin
            r_out_valid <= w_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take) begin
            r_chan <= n_chan;
        end
    end

    assign o_pix_valid = r_out_valid;
    assign o_red       = r_chan[0];
    assign o_green     = r_chan[1];
    assign o_blue      = r_chan[2];
    assign o_alpha     = r_chan[3];

endmodule
